FILE: rtl/cross_neighbour_max_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cross neighbour max filter
// Concurrent checks that can be compiled out by defining ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef CROSS_NEIGHBOUR_MAX_FILTER_UNIT_MACROS_SVH
`define CROSS_NEIGHBOUR_MAX_FILTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define CNMF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define CNMF_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define CNMF_ASSERT(name, clk, rst_n, prop)
`define CNMF_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

FILE: rtl/cnmf_pkg.sv
// ----------------------------------------------------------------------------
// Cross neighbour max filter package
// Field widths, register indexes and the types shared by the filter modules.
// ----------------------------------------------------------------------------
package cnmf_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int MAX_BITS       = PIXEL_BITS - 1;
  localparam int ROW_OUT_BITS   = 12;
  localparam int COL_OUT_BITS   = 10;
  localparam int ROWS_CFG_BITS  = 13;
  localparam int COLS_CFG_BITS  = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_COLS = 2'd1;

  localparam logic [ROWS_CFG_BITS-1:0] FRAME_ROWS_RESET = 13'd4;
  localparam logic [COLS_CFG_BITS-1:0] FRAME_COLS_RESET = 11'd5;

  typedef logic signed [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic sel;
    logic is_write;
    logic is_drain;
    logic emit;
    logic up_ok;
    logic down_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } cmd_flags_t;

  typedef struct packed {
    logic [ROW_OUT_BITS-1:0] row;
    logic [COL_OUT_BITS-1:0] col;
    logic [MAX_BITS-1:0]     nmax;
    logic                    last;
  } result_t;

endpackage

FILE: rtl/cross_neighbour_max_filter_unit.sv
// ----------------------------------------------------------------------------
// Cross neighbour max filter unit
// Takes one word per cycle while full is low.
// Rate is set by one pass through the line store read ports per word.
// Asynchronous active-low reset clears counters and queues and restores the
// default frame size of four rows by five columns.
// ----------------------------------------------------------------------------
module cross_neighbour_max_filter_unit #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cnmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [cnmf_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 mode_i,
  input  logic signed [cnmf_pkg::PIXEL_BITS-1:0] pixel_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [cnmf_pkg::ROW_OUT_BITS-1:0]    out_row_o,
  output logic [cnmf_pkg::COL_OUT_BITS-1:0]    out_col_o,
  output logic [cnmf_pkg::MAX_BITS-1:0]        neighbour_max_o,
  output logic                                 frame_last_o
);
  import cnmf_pkg::*;

  localparam int CW     = $clog2(MAX_COLS);
  localparam int CMD_W  = $bits(cmd_flags_t) + ROW_OUT_BITS + CW + PIXEL_BITS;

  logic                    accept;
  logic                    f_push;
  cmd_flags_t              f_flags;
  logic [ROW_OUT_BITS-1:0] f_row;
  logic [CW-1:0]           f_col;
  pixel_t                  f_pixel;
  logic [CMD_W-1:0]        q_in, q_out;
  logic                    q_empty, q_pop;
  logic [$clog2(4):0]      q_count;
  result_t                 res;

  assign accept = push && !full;

  cnmf_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .CW       (CW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .pixel_i     (pixel_i),
    .cmd_push_o  (f_push),
    .cmd_flags_o (f_flags),
    .cmd_row_o   (f_row),
    .cmd_col_o   (f_col),
    .cmd_pixel_o (f_pixel)
  );

  assign q_in = {f_flags, f_row, f_col, f_pixel};

  cnmf_queue #(
    .WIDTH (CMD_W),
    .DEPTH (4)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .full_o  (full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  cnmf_back #(
    .MAX_COLS (MAX_COLS),
    .CW       (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (q_pop),
    .cmd_flags_i (cmd_flags_t'(q_out[CMD_W-1 -: $bits(cmd_flags_t)])),
    .cmd_row_i   (q_out[CW+PIXEL_BITS +: ROW_OUT_BITS]),
    .cmd_col_i   (q_out[PIXEL_BITS +: CW]),
    .cmd_pixel_i (pixel_t'(q_out[PIXEL_BITS-1:0])),
    .res_pop_i   (pop),
    .res_empty_o (empty),
    .res_o       (res)
  );

  assign out_row_o       = res.row;
  assign out_col_o       = res.col;
  assign neighbour_max_o = res.nmax;
  assign frame_last_o    = res.last;

  `include "cross_neighbour_max_filter_unit_macros.svh"
  `CNMF_ASSERT(a_cmd_count_bound, clk_i, rst_ni, q_count <= ($clog2(4)+1)'(4))
  `CNMF_ASSERT(a_full_blocks_front, clk_i, rst_ni, full |-> !accept)
  `CNMF_ASSERT(a_pop_has_cmd, clk_i, rst_ni, q_pop |-> !q_empty)

endmodule

FILE: rtl/cnmf_front.sv
// ----------------------------------------------------------------------------
// Cross neighbour max filter front end
// Holds the frame size registers and position counters, drops words that do
// not apply, and turns each remaining word into a command for the back end.
// ----------------------------------------------------------------------------
`include "cross_neighbour_max_filter_unit_macros.svh"

module cnmf_front #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 4096,
  parameter int CW       = $clog2(MAX_COLS)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cnmf_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [cnmf_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  logic                                 accept_i,
  input  logic                                 mode_i,
  input  cnmf_pkg::pixel_t                     pixel_i,
  output logic                                 cmd_push_o,
  output cnmf_pkg::cmd_flags_t                 cmd_flags_o,
  output logic [cnmf_pkg::ROW_OUT_BITS-1:0]    cmd_row_o,
  output logic [CW-1:0]                        cmd_col_o,
  output cnmf_pkg::pixel_t                     cmd_pixel_o
);
  import cnmf_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);

  logic [ROWS_CFG_BITS-1:0] frame_rows_q;
  logic [COLS_CFG_BITS-1:0] frame_cols_q;
  logic [RW-1:0]            row_q, row_d;
  logic [CW-1:0]            col_q, col_d;
  logic [CW-1:0]            dcol_q, dcol_d;
  logic                     sel_q, sel_d;
  logic                     drain_pending_q, drain_pending_d;
  logic [CW-1:0]            last_col;
  logic [RW-1:0]            last_row;
  logic [31:0]              row_ext;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (frame_cols_q == '0) begin
      last_col = '0;
    end else if (32'(frame_cols_q) >= MAX_COLS) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(frame_cols_q - 1'b1);
    end
    if (frame_rows_q == '0) begin
      last_row = '0;
    end else if (32'(frame_rows_q) >= MAX_ROWS) begin
      last_row = RW'(MAX_ROWS - 1);
    end else begin
      last_row = RW'(frame_rows_q - 1'b1);
    end
  end

  always_comb begin
    row_d           = row_q;
    col_d           = col_q;
    dcol_d          = dcol_q;
    sel_d           = sel_q;
    drain_pending_d = drain_pending_q;
    cmd_flags_o     = '0;
    cmd_pixel_o     = pixel_i;
    row_ext         = '0;
    if (mode_i) begin
      cmd_push_o           = accept_i && drain_pending_q;
      cmd_col_o            = dcol_q;
      row_ext              = 32'(last_row);
      cmd_flags_o.sel      = sel_q;
      cmd_flags_o.is_drain = 1'b1;
      cmd_flags_o.emit     = 1'b1;
      cmd_flags_o.up_ok    = (last_row != '0);
      cmd_flags_o.left_ok  = (dcol_q != '0);
      cmd_flags_o.right_ok = (dcol_q < last_col);
      cmd_flags_o.last     = (dcol_q >= last_col);
      if (cmd_push_o) begin
        if (dcol_q >= last_col) begin
          drain_pending_d = 1'b0;
          dcol_d          = '0;
        end else begin
          dcol_d = dcol_q + 1'b1;
        end
      end
    end else begin
      cmd_push_o           = accept_i && !drain_pending_q;
      cmd_col_o            = col_q;
      row_ext              = 32'(row_q) - 32'd1;
      cmd_flags_o.sel      = sel_q;
      cmd_flags_o.is_write = 1'b1;
      cmd_flags_o.emit     = (row_q != '0);
      cmd_flags_o.up_ok    = (row_q > RW'(1));
      cmd_flags_o.down_ok  = 1'b1;
      cmd_flags_o.left_ok  = (col_q != '0);
      cmd_flags_o.right_ok = (col_q < last_col);
      if (cmd_push_o) begin
        if (col_q >= last_col) begin
          col_d = '0;
          sel_d = !sel_q;
          if (row_q >= last_row) begin
            row_d           = '0;
            drain_pending_d = 1'b1;
            dcol_d          = '0;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
    cmd_row_o = row_ext[ROW_OUT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q    <= FRAME_ROWS_RESET;
      frame_cols_q    <= FRAME_COLS_RESET;
      row_q           <= '0;
      col_q           <= '0;
      dcol_q          <= '0;
      sel_q           <= 1'b0;
      drain_pending_q <= 1'b0;
    end else begin
      row_q           <= row_d;
      col_q           <= col_d;
      dcol_q          <= dcol_d;
      sel_q           <= sel_d;
      drain_pending_q <= drain_pending_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_FRAME_ROWS: frame_rows_q <= cfg_data_i[ROWS_CFG_BITS-1:0];
          REG_FRAME_COLS: frame_cols_q <= cfg_data_i[COLS_CFG_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  `CNMF_ASSERT(a_drain_after_pixel, clk_i, rst_ni, $rose(drain_pending_q) |-> $past(cmd_push_o && cmd_flags_o.is_write))

endmodule

FILE: rtl/cnmf_queue.sv
// ----------------------------------------------------------------------------
// Cross neighbour max filter queue
// Small first-in first-out buffer of flip-flops with a fill count.
// ----------------------------------------------------------------------------
module cnmf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH):0]     count_o
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = entry_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/cnmf_back.sv
// ----------------------------------------------------------------------------
// Cross neighbour max filter back end
// Runs commands against the two line stores, forms the neighbour maximum and
// queues the results for the output side.
// ----------------------------------------------------------------------------
`include "cross_neighbour_max_filter_unit_macros.svh"

module cnmf_back #(
  parameter int MAX_COLS = 1024,
  parameter int CW       = $clog2(MAX_COLS)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_empty_i,
  output logic                              cmd_pop_o,
  input  cnmf_pkg::cmd_flags_t              cmd_flags_i,
  input  logic [cnmf_pkg::ROW_OUT_BITS-1:0] cmd_row_i,
  input  logic [CW-1:0]                     cmd_col_i,
  input  cnmf_pkg::pixel_t                  cmd_pixel_i,
  input  logic                              res_pop_i,
  output logic                              res_empty_o,
  output cnmf_pkg::result_t                 res_o
);
  import cnmf_pkg::*;

  localparam int RES_DEPTH = 4;
  localparam int RCW       = $clog2(RES_DEPTH) + 1;

  pixel_t mem_first  [MAX_COLS];
  pixel_t mem_second [MAX_COLS];

  pixel_t                  rd_first0_q, rd_first1_q, rd_second0_q, rd_second1_q;
  logic                    s1_valid_q;
  cmd_flags_t              s1_flags_q;
  logic [ROW_OUT_BITS-1:0] s1_row_q;
  logic [CW-1:0]           s1_col_q;
  pixel_t                  s1_pixel_q;
  pixel_t                  prev_center_q;

  logic [CW-1:0]           addr1;
  logic                    issue;
  logic [RCW-1:0]          res_cnt;
  logic [RCW:0]            res_used;
  logic                    res_full;
  logic                    res_push;
  pixel_t                  up, center, right, best;
  logic [31:0]             col_ext;
  result_t                 res_new;
  logic [$bits(result_t)-1:0] res_q_data;

  assign addr1    = (cmd_col_i == CW'(MAX_COLS - 1)) ? '0 : cmd_col_i + 1'b1;
  assign res_used = {1'b0, res_cnt} + (RCW+1)'(s1_valid_q && s1_flags_q.emit);
  assign issue    = !cmd_empty_i && (res_used < (RCW+1)'(RES_DEPTH));
  assign cmd_pop_o = issue;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_first0_q <= mem_first[cmd_col_i];
      rd_first1_q <= mem_first[addr1];
      if (cmd_flags_i.is_write && cmd_flags_i.sel) begin
        mem_first[cmd_col_i] <= cmd_pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_second0_q <= mem_second[cmd_col_i];
      rd_second1_q <= mem_second[addr1];
      if (cmd_flags_i.is_write && !cmd_flags_i.sel) begin
        mem_second[cmd_col_i] <= cmd_pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_flags_q <= cmd_flags_i;
      s1_row_q   <= cmd_row_i;
      s1_col_q   <= cmd_col_i;
      s1_pixel_q <= cmd_pixel_i;
    end
    if (s1_valid_q) begin
      prev_center_q <= center;
    end
  end

  always_comb begin
    up     = s1_flags_q.sel ? rd_first0_q  : rd_second0_q;
    center = s1_flags_q.sel ? rd_second0_q : rd_first0_q;
    right  = s1_flags_q.sel ? rd_second1_q : rd_first1_q;
    best   = '0;
    if (s1_flags_q.up_ok && up > best) begin
      best = up;
    end
    if (s1_flags_q.down_ok && s1_pixel_q > best) begin
      best = s1_pixel_q;
    end
    if (s1_flags_q.left_ok && prev_center_q > best) begin
      best = prev_center_q;
    end
    if (s1_flags_q.right_ok && right > best) begin
      best = right;
    end
    col_ext      = 32'(s1_col_q);
    res_new.row  = s1_row_q;
    res_new.col  = col_ext[COL_OUT_BITS-1:0];
    res_new.nmax = best[MAX_BITS-1:0];
    res_new.last = s1_flags_q.last;
  end

  assign res_push = s1_valid_q && s1_flags_q.emit;

  cnmf_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_new),
    .pop_i   (res_pop_i),
    .data_o  (res_q_data),
    .full_o  (res_full),
    .empty_o (res_empty_o),
    .count_o (res_cnt)
  );

  assign res_o = result_t'(res_q_data);

  `CNMF_ASSERT(a_res_credit, clk_i, rst_ni, res_push |-> !res_full)
  `CNMF_ASSERT(a_last_on_drain, clk_i, rst_ni, res_push && s1_flags_q.last |-> s1_flags_q.is_drain)
  `CNMF_ASSERT(a_down_on_pixel, clk_i, rst_ni, res_push && s1_flags_q.down_ok |-> s1_flags_q.is_write)
  `CNMF_ASSERT_NEVER(a_cnt_bound, clk_i, rst_ni, res_cnt > RCW'(RES_DEPTH))

endmodule

FILE: tb/sv/cross_neighbour_max_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cross neighbour max filter unit testbench
// Drives a short table of hand-picked words and frame sizes, then random
// frames of many sizes with random idling on both sides, and checks every
// result word against a cycle-free model of the filter or a result typed in the table.
// ----------------------------------------------------------------------------
module cross_neighbour_max_filter_unit_tb;
  import cnmf_pkg::*;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 4096;
  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int PRESSURE_WORDS = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int END_CYCLES = 20;
  localparam int RANDOM_WORDS = 1050;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    logic                      mode;
    pixel_t                    pixel;
    logic                      typed;
    result_t                   want;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      push;
  logic                      full;
  logic                      mode_i;
  pixel_t                    pixel_i;
  logic                      empty;
  logic                      pop;
  logic [ROW_OUT_BITS-1:0]   out_row_o;
  logic [COL_OUT_BITS-1:0]   out_col_o;
  logic [MAX_BITS-1:0]       neighbour_max_o;
  logic                      frame_last_o;

  pixel_t                   line_mem [2][MAX_COLS];
  bit                       cur_sel = 1'b0;
  int                       in_row = 0;
  int                       in_col = 0;
  int                       drain_at = 0;
  bit                       draining = 1'b0;
  logic [ROWS_CFG_BITS-1:0] rows_reg = FRAME_ROWS_RESET;
  logic [COLS_CFG_BITS-1:0] cols_reg = FRAME_COLS_RESET;
  int                       frames_done = 0;

  result_t   due_maxima [$];
  bit        use_typed = 1'b0;
  result_t   typed_res;
  int        accepted_words = 0;
  int        popped_words = 0;
  int        cfg_writes = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  int        calm_tx = 0;
  int        calm_rx = 0;
  bit        hold_off_req = 1'b0;
  stim_row_t directed_tab [0:25];

  cross_neighbour_max_filter_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .mode_i          (mode_i),
    .pixel_i         (pixel_i),
    .empty           (empty),
    .pop             (pop),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .neighbour_max_o (neighbour_max_o),
    .frame_last_o    (frame_last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int rows_eff();
    int r;
    r = rows_reg;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic int cols_eff();
    int c;
    c = cols_reg;
    if (c < 1) c = 1;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  // The row of the result itself is always held in the store that cur_sel picks.
  function automatic result_t cross_max_of(int row, int col, int cols, bit up_ok, int up,
                                           bit down_ok, int down, bit last);
    int      best;
    int      left;
    int      right;
    result_t res;
    best = 0;
    left = (col > 0) ? int'(line_mem[cur_sel][col-1]) : 0;
    right = (col + 1 < cols) ? int'(line_mem[cur_sel][col+1]) : 0;
    if (up_ok && up > best) best = up;
    if (down_ok && down > best) best = down;
    if (col > 0 && left > best) best = left;
    if (col + 1 < cols && right > best) best = right;
    res.row = row[ROW_OUT_BITS-1:0];
    res.col = col[COL_OUT_BITS-1:0];
    res.nmax = best[MAX_BITS-1:0];
    res.last = last;
    return res;
  endfunction

  task automatic predict_cross_max(input logic m, input pixel_t p, output bit got,
                                   output result_t res);
    int rows;
    int cols;
    int r;
    int c;
    int d;
    rows = rows_eff();
    cols = cols_eff();
    got = 1'b0;
    res = '0;
    if (m == MODE_DRAIN) begin
      if (draining) begin
        d = drain_at;
        if (d >= MAX_COLS) d = MAX_COLS - 1;
        res = cross_max_of(rows - 1, d, cols, rows >= 2, int'(line_mem[~cur_sel][d]),
                           1'b0, 0, d + 1 >= cols);
        got = 1'b1;
        if (d + 1 >= cols) begin
          draining = 1'b0;
          drain_at = 0;
          frames_done++;
        end else begin
          drain_at = d + 1;
        end
      end
    end else if (!draining) begin
      r = in_row;
      c = in_col;
      if (c >= MAX_COLS) c = MAX_COLS - 1;
      if (r >= 1) begin
        res = cross_max_of(r - 1, c, cols, r >= 2, int'(line_mem[~cur_sel][c]),
                           1'b1, int'(p), 1'b0);
        got = 1'b1;
      end
      line_mem[~cur_sel][c] = p;
      if (c + 1 >= cols) begin
        in_col = 0;
        cur_sel = ~cur_sel;
        if (r + 1 >= rows) begin
          in_row = 0;
          draining = 1'b1;
          drain_at = 0;
        end else begin
          in_row = r + 1;
        end
      end else begin
        in_col = c + 1;
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, seen);
    end
  endtask

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm = $urandom_range(20, 60);
    return $urandom_range(0, 12);
  endfunction

  always @(posedge clk_i) begin
    bit      got;
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FRAME_ROWS: rows_reg = cfg_data_i[ROWS_CFG_BITS-1:0];
          REG_FRAME_COLS: cols_reg = cfg_data_i[COLS_CFG_BITS-1:0];
          default: ;
        endcase
        cfg_writes++;
        moved = 1'b1;
      end
      if (push && !full) begin
        predict_cross_max(mode_i, pixel_i, got, want);
        if (got) due_maxima.push_back(use_typed ? typed_res : want);
        accepted_words++;
        moved = 1'b1;
      end
      if (pop && !empty) begin
        if (due_maxima.size() == 0) begin
          mismatches++;
          $display("%0t: word row %0d col %0d arrived with none expected",
                   $time, out_row_o, out_col_o);
        end else begin
          want = due_maxima.pop_front();
          compare_field("out_row", want.row, out_row_o);
          compare_field("out_col", want.col, out_col_o);
          compare_field("neighbour_max", want.nmax, neighbour_max_o);
          compare_field("frame_last", want.last, frame_last_o);
        end
        popped_words++;
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Entered and left at a falling edge; the word stays offered until taken.
  task automatic offer_word(input logic m, input pixel_t p);
    int gap;
    int seen;
    gap = draw_gap(calm_tx);
    for (int i = 0; i < gap; i++) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    mode_i <= m;
    pixel_i <= p;
    seen = accepted_words;
    do @(negedge clk_i); while (accepted_words == seen);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    int seen;
    push <= 1'b0;
    while (due_maxima.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    seen = cfg_writes;
    do @(negedge clk_i); while (cfg_writes == seen);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int gap;
    int seen;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        repeat (HOLD_OFF_CYCLES) begin
          pop <= 1'b0;
          @(negedge clk_i);
        end
      end
      gap = draw_gap(calm_rx);
      for (int i = 0; i < gap; i++) begin
        pop <= 1'b0;
        @(negedge clk_i);
      end
      pop <= 1'b1;
      seen = popped_words;
      do @(negedge clk_i); while (popped_words == seen);
    end
  end

  initial begin
    int                       k;
    int                       frames;
    int                       target;
    int                       random_words;
    int                       rows_val;
    int                       cols_val;
    logic [CFG_DATA_BITS-1:0] rows_data;
    logic [CFG_DATA_BITS-1:0] cols_data;
    bit                       noise;
    logic                     m;
    pixel_t                   p;
    rst_ni <= 1'b0;
    push <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    mode_i <= MODE_PIXEL;
    pixel_i <= '0;
    directed_tab = '{
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'sh7FFF, 1'b0, '0},
      '{ROW_CFG, REG_FRAME_ROWS, 16'h0002, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_CFG, REG_FRAME_COLS, 16'h0003, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh7FFF, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh8000, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'shFFFF, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh0000, 1'b1, '{12'd0, 10'd0, 15'd0, 1'b0}},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh0001, 1'b1, '{12'd0, 10'd1, 15'd32767, 1'b0}},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh8000, 1'b1, '{12'd0, 10'd2, 15'd0, 1'b0}},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'sh5A5A, 1'b1, '{12'd1, 10'd0, 15'd32767, 1'b0}},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh1234, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'shA5A5, 1'b1, '{12'd1, 10'd1, 15'd0, 1'b0}},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'shFFFF, 1'b1, '{12'd1, 10'd2, 15'd1, 1'b1}},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'sh0000, 1'b0, '0},
      '{ROW_CFG, REG_FRAME_ROWS, 16'hE000, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_CFG, REG_FRAME_COLS, 16'hF800, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_CFG, REG_SPARE_LO, 16'hFFFF, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_CFG, REG_SPARE_HI, 16'hAAAA, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh7FFF, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'sh8000, 1'b1, '{12'd0, 10'd0, 15'd0, 1'b1}},
      '{ROW_CFG, REG_FRAME_ROWS, 16'h0003, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_CFG, REG_FRAME_COLS, 16'h0001, MODE_PIXEL, '0, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh0064, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'shFFFB, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_PIXEL, 16'sh00C8, 1'b0, '0},
      '{ROW_WORD, '0, '0, MODE_DRAIN, 16'sh0000, 1'b0, '0}
    };
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_tab[i]) begin
      if (directed_tab[i].kind == ROW_CFG) begin
        write_reg(directed_tab[i].index, directed_tab[i].data);
      end else begin
        use_typed = directed_tab[i].typed;
        typed_res = directed_tab[i].want;
        offer_word(directed_tab[i].mode, directed_tab[i].pixel);
        use_typed = 1'b0;
      end
    end

    // Frame sizes change only at a frame boundary, so no store entry is read unwritten.
    k = 0;
    random_words = 0;
    while (k < 10 || random_words < RANDOM_WORDS) begin
      frames = 1;
      case (k)
        1: begin
          rows_val = 6;
          cols_val = 9;
        end
        3: begin
          rows_val = 1;
          cols_val = 12;
        end
        5: begin
          rows_val = 2;
          cols_val = 40;
        end
        7: begin
          rows_val = 12;
          cols_val = 1;
        end
        default: begin
          rows_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 6);
          cols_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 9);
          frames = $urandom_range(1, 3);
        end
      endcase
      if (k == 9) begin
        rows_val = FRAME_ROWS_RESET;
        cols_val = FRAME_COLS_RESET;
      end
      rows_data = CFG_DATA_BITS'($urandom);
      rows_data[ROWS_CFG_BITS-1:0] = ROWS_CFG_BITS'(rows_val);
      cols_data = CFG_DATA_BITS'($urandom);
      cols_data[COLS_CFG_BITS-1:0] = COLS_CFG_BITS'(cols_val);
      write_reg(REG_FRAME_ROWS, rows_data);
      write_reg(REG_FRAME_COLS, cols_data);
      if (k == 1) begin
        hold_off_req = 1'b1;
        calm_tx = PRESSURE_WORDS;
      end
      target = frames_done + frames;
      while (frames_done < target) begin
        noise = ($urandom_range(0, 11) == 0);
        m = draining ^ noise;
        case ($urandom_range(0, 7))
          0: p = 16'sh7FFF;
          1: p = 16'sh8000;
          2, 3: p = pixel_t'(int'($urandom_range(0, 400)) - 200);
          default: p = pixel_t'($urandom);
        endcase
        offer_word(m, p);
        random_words++;
      end
      k++;
    end

    push <= 1'b0;
    while (due_maxima.size() != 0) @(negedge clk_i);
    repeat (END_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && due_maxima.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cnmf_pkg.sv
rtl/cnmf_front.sv
rtl/cnmf_queue.sv
rtl/cnmf_back.sv
rtl/cross_neighbour_max_filter_unit.sv
tb/sv/cross_neighbour_max_filter_unit_tb.sv
